// File: hdl/palist_pkg.sv
package palist_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int REQ_USER_W = 3;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 2;

   localparam logic [2:0] CMD_INS_POS   = 3'd0;
   localparam logic [2:0] CMD_DEL_POS   = 3'd1;
   localparam logic [2:0] CMD_INS_FRONT = 3'd2;
   localparam logic [2:0] CMD_INS_END   = 3'd3;
   localparam logic [2:0] CMD_DEL_FRONT = 3'd4;
   localparam logic [2:0] CMD_DEL_END   = 3'd5;
   localparam logic [2:0] CMD_READ      = 3'd6;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_EMPTY  = 2'd2;
   localparam logic [1:0] ST_BADPOS = 2'd3;

   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_INSERT = 3'd1;
   localparam logic [2:0] KIND_DELETE = 3'd2;
   localparam logic [2:0] KIND_DROP   = 3'd3;
   localparam logic [2:0] KIND_READ   = 3'd4;

   typedef struct packed {
      logic load_req;
      logic latch_status;
      logic init_up;
      logic init_down;
      logic up_rd;
      logic up_wr;
      logic put;
      logic down_rd;
      logic down_wr;
      logic drop;
      logic rd_issue;
      logic load_rsp;
   } palist_ctl_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       up_more;
      logic       down_more;
      logic       rsp_free;
   } palist_sts_type;

endpackage

// File: hdl/palist_datapath.sv
module palist_datapath #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [2:0]                        req_cmd,
   input  logic [7:0]                        req_position,
   input  logic signed [31:0]                req_value,
   input  palist_pkg::palist_ctl_type        ctl,
   output palist_pkg::palist_sts_type        sts,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic signed [31:0]                rsp_read_value,
   output logic [7:0]                        rsp_length
);
   import palist_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = ((CW > 8) ? CW : 8) + 1;
   localparam int WW = (DATA_WIDTH > 32) ? DATA_WIDTH : 32;

   logic [2:0]            cmd_ff;
   logic [7:0]            pos_ff;
   logic signed [31:0]    value_ff;
   logic [CW-1:0]         count_ff, count_in;
   logic [AW-1:0]         index_ff, index_in;
   logic [DATA_WIDTH-1:0] mem_ff [CAPACITY];
   logic [DATA_WIDTH-1:0] rd_data_ff;
   logic [1:0]            status_ff;
   logic                  is_read_ff;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_status_ff;
   logic signed [31:0]    rsp_read_value_ff;
   logic [7:0]            rsp_length_ff;

   logic                  full, empty, ins_pos_ok, del_pos_ok;
   logic [PW-1:0]         pos_w, cnt_w;
   logic [1:0]            status_dec;
   logic [2:0]            kind_dec;
   logic [AW-1:0]         tgt;
   logic [AW-1:0]         pos_idx;
   logic                  mem_we, mem_re;
   logic [AW-1:0]         wr_addr, rd_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [WW-1:0]         value_wide, rd_wide;

   assign full       = (count_ff == CW'(CAPACITY));
   assign empty      = (count_ff == '0);
   assign pos_w      = PW'(pos_ff);
   assign cnt_w      = PW'(count_ff);
   assign ins_pos_ok = (pos_ff != 8'd0) && (pos_w <= cnt_w + PW'(1));
   assign del_pos_ok = (pos_ff != 8'd0) && (pos_w <= cnt_w);
   assign pos_idx    = AW'(pos_ff - 8'd1);

   always_comb begin
      status_dec = ST_OK;
      kind_dec   = KIND_NONE;
      tgt        = '0;
      case (cmd_ff)
         CMD_INS_POS: begin
            if (full) begin
               status_dec = ST_FULL;
            end else if (!ins_pos_ok) begin
               status_dec = ST_BADPOS;
            end else begin
               kind_dec = KIND_INSERT;
               tgt      = pos_idx;
            end
         end
         CMD_DEL_POS: begin
            if (empty) begin
               status_dec = ST_EMPTY;
            end else if (!del_pos_ok) begin
               status_dec = ST_BADPOS;
            end else begin
               kind_dec = KIND_DELETE;
               tgt      = pos_idx;
            end
         end
         CMD_INS_FRONT: begin
            if (full) begin
               status_dec = ST_FULL;
            end else begin
               kind_dec = KIND_INSERT;
            end
         end
         CMD_INS_END: begin
            if (full) begin
               status_dec = ST_FULL;
            end else begin
               kind_dec = KIND_INSERT;
               tgt      = AW'(count_ff);
            end
         end
         CMD_DEL_FRONT: begin
            if (empty) begin
               status_dec = ST_EMPTY;
            end else begin
               kind_dec = KIND_DELETE;
            end
         end
         CMD_DEL_END: begin
            if (empty) begin
               status_dec = ST_EMPTY;
            end else begin
               kind_dec = KIND_DROP;
            end
         end
         CMD_READ: begin
            if (empty) begin
               status_dec = ST_EMPTY;
            end else if (!del_pos_ok) begin
               status_dec = ST_BADPOS;
            end else begin
               kind_dec = KIND_READ;
               tgt      = pos_idx;
            end
         end
         default: begin
            status_dec = ST_OK;
         end
      endcase
   end

   assign sts.kind      = kind_dec;
   assign sts.up_more   = (index_ff > tgt);
   assign sts.down_more = ((CW + 1)'(index_ff) + (CW + 1)'(1)) < (CW + 1)'(count_ff);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   // shift index walks the entries to be moved
   always_comb begin
      index_in = index_ff;
      if (ctl.init_up) begin
         index_in = AW'(count_ff);
      end else if (ctl.init_down) begin
         index_in = tgt;
      end else if (ctl.up_wr) begin
         index_in = index_ff - AW'(1);
      end else if (ctl.down_wr) begin
         index_in = index_ff + AW'(1);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.put) begin
         count_in = count_ff + CW'(1);
      end else if (ctl.drop) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign value_wide = WW'(value_ff);
   assign rd_wide    = WW'($signed(rd_data_ff));

   assign mem_we  = ctl.up_wr || ctl.down_wr || ctl.put;
   assign mem_re  = ctl.up_rd || ctl.down_rd || ctl.rd_issue;
   assign wr_addr = ctl.put ? tgt : index_ff;
   assign wr_data = ctl.put ? value_wide[DATA_WIDTH-1:0] : rd_data_ff;

   always_comb begin
      rd_addr = tgt;
      if (ctl.up_rd) begin
         rd_addr = index_ff - AW'(1);
      end else if (ctl.down_rd) begin
         rd_addr = index_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load_req) begin
         cmd_ff   <= req_cmd;
         pos_ff   <= req_position;
         value_ff <= req_value;
      end
      if (ctl.latch_status) begin
         status_ff  <= status_dec;
         is_read_ff <= (kind_dec == KIND_READ);
      end
      index_ff <= index_in;
      if (ctl.load_rsp) begin
         rsp_status_ff     <= status_ff;
         rsp_read_value_ff <= is_read_ff ? $signed(rd_wide[31:0]) : 32'sd0;
         rsp_length_ff     <= 8'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (ctl.load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_value = rsp_read_value_ff;
   assign rsp_length     = rsp_length_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("entry count above capacity");

   a_count_change: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> ($past(ctl.put) || $past(ctl.drop)))
      else $error("entry count changed without put or drop");

   a_rsp_slot: assert property (@(posedge clock) disable iff (reset)
      ctl.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response loaded over a pending response");

endmodule

// File: hdl/palist_controller.sv
module palist_controller (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  palist_pkg::palist_sts_type sts,
   output palist_pkg::palist_ctl_type ctl
);
   import palist_pkg::*;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_EVAL    = 4'd1;
   localparam logic [3:0] S_UP_RD   = 4'd2;
   localparam logic [3:0] S_UP_WR   = 4'd3;
   localparam logic [3:0] S_PUT     = 4'd4;
   localparam logic [3:0] S_DOWN_RD = 4'd5;
   localparam logic [3:0] S_DOWN_WR = 4'd6;
   localparam logic [3:0] S_RESP    = 4'd7;

   logic [3:0] state_ff, state_in;

   assign req_ready = !reset && (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      ctl      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctl.load_req = 1'b1;
               state_in     = S_EVAL;
            end
         end
         S_EVAL: begin
            ctl.latch_status = 1'b1;
            case (sts.kind)
               KIND_INSERT: begin
                  ctl.init_up = 1'b1;
                  state_in    = S_UP_RD;
               end
               KIND_DELETE: begin
                  ctl.init_down = 1'b1;
                  state_in      = S_DOWN_RD;
               end
               KIND_DROP: begin
                  ctl.drop = 1'b1;
                  state_in = S_RESP;
               end
               KIND_READ: begin
                  ctl.rd_issue = 1'b1;
                  state_in     = S_RESP;
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_UP_RD: begin
            if (sts.up_more) begin
               ctl.up_rd = 1'b1;
               state_in  = S_UP_WR;
            end else begin
               state_in = S_PUT;
            end
         end
         S_UP_WR: begin
            ctl.up_wr = 1'b1;
            state_in  = S_UP_RD;
         end
         S_PUT: begin
            ctl.put  = 1'b1;
            state_in = S_RESP;
         end
         S_DOWN_RD: begin
            if (sts.down_more) begin
               ctl.down_rd = 1'b1;
               state_in    = S_DOWN_WR;
            end else begin
               ctl.drop = 1'b1;
               state_in = S_RESP;
            end
         end
         S_DOWN_WR: begin
            ctl.down_wr = 1'b1;
            state_in    = S_DOWN_RD;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && req_valid) |=> (state_ff == S_EVAL))
      else $error("accepted request not evaluated");

   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RESP && !sts.rsp_free) |=> (state_ff == S_RESP))
      else $error("response state left while output busy");

endmodule

// File: hdl/positional_array_list_unit.sv
// refused commands, reads and delete at end pass from evaluation straight to the response state
// insert shifts entries from the target up, then writes the value; delete shifts later ones down
// each moved entry takes one memory read and one memory write on the single port pair
// one request at a time; the next is taken the cycle after its result enters the output register
// reset clears the entry count, controller and output valid; the entry memory is not cleared
module positional_array_list_unit #(
   parameter int CAPACITY   = 128,
   parameter int DATA_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [palist_pkg::REQ_DATA_W-1:0]   req_tdata,  // position[7:0], value[39:8]
   input  logic [palist_pkg::REQ_USER_W-1:0]   req_tuser,  // cmd[2:0]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [palist_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // read_value[31:0], length[39:32]
   output logic [palist_pkg::RSP_USER_W-1:0]   rsp_tuser   // status[1:0]
);
   import palist_pkg::*;

   palist_ctl_type     ctl;
   palist_sts_type     sts;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_read_value;
   logic [7:0]         rsp_length;

   palist_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .ctl       (ctl)
   );

   palist_datapath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .req_cmd        (req_tuser[2:0]),
      .req_position   (req_tdata[7:0]),
      .req_value      ($signed(req_tdata[39:8])),
      .ctl            (ctl),
      .sts            (sts),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value),
      .rsp_length     (rsp_length)
   );

   assign rsp_tdata = {rsp_length, rsp_read_value};
   assign rsp_tuser = rsp_status;

endmodule
